@@ rtl/mrtu_pkg.sv @@
// Shared types and codes of the Modbus RTU master transaction unit.
`default_nettype none
package mrtu_pkg;

  localparam logic [2:0] REQ_READ  = 3'd0;
  localparam logic [2:0] REQ_WRITE = 3'd1;
  localparam logic [2:0] REQ_PAY   = 3'd2;
  localparam logic [2:0] REQ_RX    = 3'd3;
  localparam logic [2:0] REQ_TICK  = 3'd4;

  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_PAY    = 2'd2;

  localparam logic [3:0] ST_OK      = 4'd0;
  localparam logic [3:0] ST_ID_ERR  = 4'd1;
  localparam logic [3:0] ST_FN_ERR  = 4'd2;
  localparam logic [3:0] ST_EXCEPT  = 4'd3;
  localparam logic [3:0] ST_CRC_ERR = 4'd4;
  localparam logic [3:0] ST_SHORT   = 4'd5;
  localparam logic [3:0] ST_OVERFL  = 4'd6;
  localparam logic [3:0] ST_WAITING = 4'd7;
  localparam logic [3:0] ST_ABNORM  = 4'd8;
  localparam logic [3:0] ST_LOST    = 4'd9;
  localparam logic [3:0] ST_BUSY    = 4'd10;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [7:0]  FN_WRITE_MULTI = 8'h10;
  localparam logic [7:0]  FN_EXC_FLAG    = 8'h80;
  localparam int          PAY_CAP        = 63;
  localparam int          MIN_FRAME      = 5;

  localparam logic [2:0] REG_SLAVE   = 3'd0;
  localparam logic [2:0] REG_TIMEOUT = 3'd4;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_READ,
    MODE_WPAY,
    MODE_WWAIT
  } mode_t;

  typedef struct packed {
    logic       init;
    logic       feed;
    logic [7:0] data;
  } crc_cmd_t;

endpackage
`default_nettype wire

@@ rtl/modbus_rtu_master_transaction_unit.sv @@
// Modbus RTU master: request framing, reply buffering and frame checking.
//
// Input stream s_*: tuser carries the request kind, tlast marks the last write
// payload byte, tdata the remaining fields. Output stream m_*: tuser is the
// result kind (transmit byte, status, read payload byte), tlast flags the last
// result of an input item. Registers slave_address (0x0) and timeout_ticks
// (0x4) sit on the APB port; the user must write them only while the block
// is idle, as the block itself does not enforce this. The block takes one
// item at a time; s_tready is high only in its idle state. Received bytes
// that fit the buffer and ignored items are taken without leaving it.
// The frame-closing tick walks the reply buffer through one read port, once
// through the shared CRC unit for the CRC pass and again for payload bytes.
// Results wait in an output register; while the receiver stalls, an emitted
// byte is held and the emitting states wait, but the idle state still
// accepts items. Reset empties the output register, sets idle link mode and
// restores slave_address 1 and timeout_ticks 25.
`default_nettype none
module modbus_rtu_master_transaction_unit #(
  parameter int FRAME_BYTES    = 64,
  parameter int ABNORMAL_LIMIT = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // func_code[7:0], reg_address[23:8], reg_count[30:24], data_byte[38:31]
  input  wire logic [39:0] s_tdata,
  // req_type[2:0]
  input  wire logic [2:0]  s_tuser,
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // out_byte[7:0], status[11:8], exception_code[19:12]
  output logic [23:0]      m_tdata,
  // result_kind[1:0]
  output logic [1:0]       m_tuser,
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int LW = $clog2(FRAME_BYTES + 1);
  localparam int PW = LW + 7;

  typedef enum logic [3:0] {
    S_IDLE, S_STAT, S_HDR, S_PB, S_WAIT, S_B0, S_B1, S_EXC,
    S_CRC, S_CKLO, S_CKHI, S_PAY
  } state_t;

  state_t          state, ret;
  mrtu_pkg::mode_t mode;
  logic [7:0]      slave_address;
  logic [15:0]     timeout_ticks;
  logic            started;
  logic [LW-1:0]   flen, clen, idx;
  logic [15:0]     scnt;
  logic [7:0]      pend;
  logic [2:0]      hidx;
  logic            hdr_rd, close_rd, crc_bad;
  logic [AW-1:0]   raddr;
  logic [3:0]      stat_code;
  logic [7:0]      exc_code;
  logic [15:0]     f_addr;
  logic [6:0]      f_cnt;
  logic [7:0]      f_byte;
  logic            f_fin;

  logic [7:0]         o_byte, o_exc;
  logic [3:0]         o_stat;
  logic [1:0]         o_kind;
  logic               o_valid, o_last, o_load;

  logic               accept, out_free, rx_mode, hdr_last;
  logic [2:0]         req;
  logic [7:0]         hdr_byte, rd_data;
  logic [15:0]        crc, sc_next;
  logic [LW-1:0]      plen;
  logic [PW-1:0]      pcnt;
  mrtu_pkg::crc_cmd_t crc_cmd;
  logic               mem_we;

  assign pready   = 1'b1;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign req      = s_tuser;
  assign out_free = !o_valid || m_tready;
  assign o_load   = out_free && (state inside {S_STAT, S_HDR, S_PB, S_PAY});
  assign rx_mode  = (mode == mrtu_pkg::MODE_READ) || (mode == mrtu_pkg::MODE_WWAIT);
  assign sc_next  = (scnt == 16'hFFFF) ? scnt : scnt + 16'd1;
  assign plen     = clen - LW'(mrtu_pkg::MIN_FRAME);
  assign pcnt     = (PW'(plen) > PW'(mrtu_pkg::PAY_CAP)) ? PW'(mrtu_pkg::PAY_CAP) : PW'(plen);
  assign hdr_last = hdr_rd ? (hidx == 3'd7) : (hidx == 3'd6);

  assign m_tvalid = o_valid;
  assign m_tdata  = {4'h0, o_exc, o_stat, o_byte};
  assign m_tuser  = o_kind;
  assign m_tlast  = o_last;

  always_comb begin
    case (paddr)
      mrtu_pkg::REG_SLAVE:   prdata = {24'h0, slave_address};
      mrtu_pkg::REG_TIMEOUT: prdata = {16'h0, timeout_ticks};
      default:               prdata = 32'h0;
    endcase
  end

  always_comb begin
    case (hidx)
      3'd0:    hdr_byte = slave_address;
      3'd1:    hdr_byte = pend;
      3'd2:    hdr_byte = f_addr[15:8];
      3'd3:    hdr_byte = f_addr[7:0];
      3'd4:    hdr_byte = 8'h00;
      3'd5:    hdr_byte = {1'b0, f_cnt};
      3'd6:    hdr_byte = hdr_rd ? crc[7:0] : {f_cnt, 1'b0};
      default: hdr_byte = crc[15:8];
    endcase
  end

  always_comb begin
    crc_cmd = '0;
    mem_we  = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept && (req == mrtu_pkg::REQ_READ || req == mrtu_pkg::REQ_WRITE) &&
            mode == mrtu_pkg::MODE_IDLE) begin
          crc_cmd.init = 1'b1;
        end
        if (accept && req == mrtu_pkg::REQ_RX && rx_mode &&
            flen < LW'(FRAME_BYTES)) begin
          mem_we = 1'b1;
        end
      end
      S_HDR: begin
        crc_cmd.data = hdr_byte;
        crc_cmd.feed = out_free && (hidx <= 3'd5 || (hidx == 3'd6 && !hdr_rd));
      end
      S_PB: begin
        crc_cmd.data = f_byte;
        crc_cmd.feed = out_free;
      end
      S_B1: begin
        crc_cmd.init = (rd_data == pend);
      end
      S_CRC: begin
        crc_cmd.data = rd_data;
        crc_cmd.feed = 1'b1;
      end
      default: ;
    endcase
  end

  mrtu_crc u_crc (
    .clk (clk),
    .rst (rst),
    .cmd (crc_cmd),
    .crc (crc)
  );

  mrtu_frame #(.AW(AW)) u_frame (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(flen)),
    .wdata (s_tdata[38:31]),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd1;
      timeout_ticks <= 16'd25;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        mrtu_pkg::REG_SLAVE:   slave_address <= pwdata[7:0];
        mrtu_pkg::REG_TIMEOUT: timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ret     <= S_IDLE;
      mode    <= mrtu_pkg::MODE_IDLE;
      started <= 1'b0;
      flen    <= '0;
      scnt    <= '0;
      pend    <= '0;
      o_valid <= 1'b0;
    end else begin
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            f_addr   <= s_tdata[23:8];
            f_cnt    <= s_tdata[30:24];
            f_byte   <= s_tdata[38:31];
            f_fin    <= s_tlast;
            exc_code <= 8'h00;
            case (req)
              mrtu_pkg::REQ_READ, mrtu_pkg::REQ_WRITE: begin
                if (mode != mrtu_pkg::MODE_IDLE) begin
                  stat_code <= mrtu_pkg::ST_BUSY;
                  state     <= S_STAT;
                end else begin
                  pend    <= (req == mrtu_pkg::REQ_READ) ? s_tdata[7:0]
                                                          : mrtu_pkg::FN_WRITE_MULTI;
                  hidx    <= 3'd0;
                  hdr_rd  <= (req == mrtu_pkg::REQ_READ);
                  mode    <= (req == mrtu_pkg::REQ_READ) ? mrtu_pkg::MODE_READ
                                                          : mrtu_pkg::MODE_WPAY;
                  started <= 1'b0;
                  flen    <= '0;
                  scnt    <= '0;
                  state   <= S_HDR;
                end
              end
              mrtu_pkg::REQ_PAY: begin
                if (mode == mrtu_pkg::MODE_WPAY) begin
                  state <= S_PB;
                end
              end
              mrtu_pkg::REQ_RX: begin
                if (rx_mode) begin
                  started <= 1'b1;
                  if (flen < LW'(FRAME_BYTES)) begin
                    flen <= flen + LW'(1);
                  end else begin
                    stat_code <= mrtu_pkg::ST_OVERFL;
                    state     <= S_STAT;
                  end
                end
              end
              mrtu_pkg::REQ_TICK: begin
                if (rx_mode) begin
                  if (started) begin
                    close_rd <= (mode == mrtu_pkg::MODE_READ);
                    clen     <= flen;
                    mode     <= mrtu_pkg::MODE_IDLE;
                    started  <= 1'b0;
                    flen     <= '0;
                    scnt     <= '0;
                    if (flen < LW'(mrtu_pkg::MIN_FRAME)) begin
                      stat_code <= mrtu_pkg::ST_SHORT;
                      state     <= S_STAT;
                    end else begin
                      raddr <= '0;
                      ret   <= S_B0;
                      state <= S_WAIT;
                    end
                  end else begin
                    state <= S_STAT;
                    if (sc_next > timeout_ticks) begin
                      stat_code <= mrtu_pkg::ST_LOST;
                      mode      <= mrtu_pkg::MODE_IDLE;
                      flen      <= '0;
                      scnt      <= '0;
                    end else if (sc_next > 16'(ABNORMAL_LIMIT)) begin
                      scnt      <= sc_next;
                      stat_code <= mrtu_pkg::ST_ABNORM;
                    end else begin
                      scnt      <= sc_next;
                      stat_code <= mrtu_pkg::ST_WAITING;
                    end
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_STAT: begin
          if (out_free) begin
            o_kind  <= mrtu_pkg::KIND_STATUS;
            o_byte  <= 8'h00;
            o_stat  <= stat_code;
            o_exc   <= exc_code;
            o_last  <= 1'b1;
            state   <= S_IDLE;
          end
        end
        S_HDR: begin
          if (out_free) begin
            o_kind  <= mrtu_pkg::KIND_TX;
            o_byte  <= hdr_byte;
            o_stat  <= mrtu_pkg::ST_OK;
            o_exc   <= 8'h00;
            o_last  <= hdr_last;
            hidx    <= hidx + 3'd1;
            if (hdr_last) begin
              state <= S_IDLE;
            end
          end
        end
        S_PB: begin
          if (out_free) begin
            o_kind  <= mrtu_pkg::KIND_TX;
            o_byte  <= f_byte;
            o_stat  <= mrtu_pkg::ST_OK;
            o_exc   <= 8'h00;
            o_last  <= !f_fin;
            if (f_fin) begin
              // append the CRC tail and wait for the reply
              hidx    <= 3'd6;
              hdr_rd  <= 1'b1;
              mode    <= mrtu_pkg::MODE_WWAIT;
              started <= 1'b0;
              flen    <= '0;
              scnt    <= '0;
              state   <= S_HDR;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_WAIT: begin
          state <= ret;
        end
        S_B0: begin
          if (rd_data != slave_address) begin
            stat_code <= mrtu_pkg::ST_ID_ERR;
            state     <= S_STAT;
          end else begin
            raddr <= AW'(1);
            ret   <= S_B1;
            state <= S_WAIT;
          end
        end
        S_B1: begin
          if (rd_data != pend) begin
            if (rd_data == (pend | mrtu_pkg::FN_EXC_FLAG)) begin
              raddr <= AW'(2);
              ret   <= S_EXC;
              state <= S_WAIT;
            end else begin
              stat_code <= mrtu_pkg::ST_FN_ERR;
              state     <= S_STAT;
            end
          end else begin
            idx   <= '0;
            raddr <= '0;
            ret   <= S_CRC;
            state <= S_WAIT;
          end
        end
        S_EXC: begin
          stat_code <= mrtu_pkg::ST_EXCEPT;
          exc_code  <= rd_data;
          state     <= S_STAT;
        end
        S_CRC: begin
          state <= S_WAIT;
          if (idx + LW'(1) < clen - LW'(2)) begin
            idx   <= idx + LW'(1);
            raddr <= AW'(idx + LW'(1));
            ret   <= S_CRC;
          end else begin
            raddr <= AW'(clen - LW'(2));
            ret   <= S_CKLO;
          end
        end
        S_CKLO: begin
          crc_bad <= (rd_data != crc[7:0]);
          raddr   <= AW'(clen - LW'(1));
          ret     <= S_CKHI;
          state   <= S_WAIT;
        end
        S_CKHI: begin
          if (crc_bad || rd_data != crc[15:8]) begin
            stat_code <= mrtu_pkg::ST_CRC_ERR;
            state     <= S_STAT;
          end else if (close_rd && pcnt != '0) begin
            idx   <= '0;
            raddr <= AW'(3);
            ret   <= S_PAY;
            state <= S_WAIT;
          end else begin
            stat_code <= mrtu_pkg::ST_OK;
            state     <= S_STAT;
          end
        end
        S_PAY: begin
          if (out_free) begin
            o_kind  <= mrtu_pkg::KIND_PAY;
            o_byte  <= rd_data;
            o_stat  <= mrtu_pkg::ST_OK;
            o_exc   <= 8'h00;
            o_last  <= 1'b0;
            if (PW'(idx) + PW'(1) < pcnt) begin
              idx   <= idx + LW'(1);
              raddr <= AW'(idx + LW'(4));
              ret   <= S_PAY;
              state <= S_WAIT;
            end else begin
              stat_code <= mrtu_pkg::ST_OK;
              state     <= S_STAT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/mrtu_crc.sv @@
// Shared CRC-16 unit: clears or folds one byte per cycle.
`default_nettype none
module mrtu_crc (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mrtu_pkg::crc_cmd_t cmd,
  output logic [15:0]           crc
);

  logic [15:0] crc_next;

  always_comb begin
    crc_next = crc ^ {8'h00, cmd.data};
    for (int k = 0; k < 8; k++) begin
      if (crc_next[0]) begin
        crc_next = (crc_next >> 1) ^ mrtu_pkg::CRC_POLY;
      end else begin
        crc_next = crc_next >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= mrtu_pkg::CRC_INIT;
    end else if (cmd.init) begin
      crc <= mrtu_pkg::CRC_INIT;
    end else if (cmd.feed) begin
      crc <= crc_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/mrtu_frame.sv @@
// Reply byte buffer: one write port, one registered read port.
`default_nettype none
module mrtu_frame #(
  parameter int AW = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [7:0]         rdata
);

  logic [7:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/mrtu_checker.sv @@
// Port-level checks of the Modbus RTU master transaction unit.
`default_nettype none
module mrtu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata,
  input wire logic [1:0]  m_tuser,
  input wire logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output item changed");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == mrtu_pkg::KIND_STATUS |-> m_tlast && m_tdata[7:0] == 8'h00)
    else $error("status item not last or carries a byte");

  a_byte_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != mrtu_pkg::KIND_STATUS |-> m_tdata[19:8] == 12'h000 &&
    (m_tuser == mrtu_pkg::KIND_TX || m_tuser == mrtu_pkg::KIND_PAY))
    else $error("byte item with status fields or bad kind");

endmodule

bind modbus_rtu_master_transaction_unit mrtu_checker u_mrtu_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
`default_nettype wire
